// ----- hdl/swm_pkg.sv -----
// Shared constants and types for the sliding window maximum unit.
`default_nettype none
package swm_pkg;

  localparam int SampleBitsDef = 32;
  localparam int MaxWindowDef  = 64;
  localparam int CfgBits       = 7;

  localparam logic [CfgBits-1:0] WindowReset = 7'd8;

  // Per-cycle command that the top level broadcasts to every cell.
  typedef struct packed {
    logic load;   // a sample beat is accepted this cycle
    logic pop;    // the front entry leaves and every cell takes its right neighbor
    logic clear;  // the sequence ends, every entry is invalidated
  } swm_ctl_t;

endpackage
`default_nettype wire

// ----- hdl/swm_cell.sv -----
// One deque cell: holds an entry and hands it to its left neighbor on a front pop.
`default_nettype none
module swm_cell
  import swm_pkg::*;
#(
  parameter int SAMPLE_BITS = SampleBitsDef,
  parameter int POS_BITS    = 6
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  swm_ctl_t                      ctl_i,
  input  wire signed [SAMPLE_BITS-1:0]  sample_i,
  input  wire        [POS_BITS-1:0]     pos_i,
  input  wire                           prev_keep_i,
  input  wire                           next_valid_i,
  input  wire signed [SAMPLE_BITS-1:0]  next_value_i,
  input  wire        [POS_BITS-1:0]     next_pos_i,
  output logic                          valid_o,
  output logic signed [SAMPLE_BITS-1:0] value_o,
  output logic       [POS_BITS-1:0]     pos_o,
  output logic                          keep_o
);

  logic                          valid_q, valid_d;
  logic signed [SAMPLE_BITS-1:0] value_q, value_d;
  logic        [POS_BITS-1:0]    pos_q, pos_d;
  logic                          e_valid;
  logic signed [SAMPLE_BITS-1:0] e_value;
  logic        [POS_BITS-1:0]    e_pos;

  always_comb begin
    e_valid = ctl_i.pop ? next_valid_i : valid_q;
    e_value = ctl_i.pop ? next_value_i : value_q;
    e_pos   = ctl_i.pop ? next_pos_i   : pos_q;
    // An entry survives only while it is strictly larger than the new sample.
    keep_o  = e_valid & (e_value > sample_i);

    valid_d = valid_q;
    value_d = value_q;
    pos_d   = pos_q;
    if (ctl_i.clear) begin
      valid_d = 1'b0;
    end else if (ctl_i.load) begin
      // The survivors form a prefix; the new sample lands right after it.
      valid_d = keep_o | prev_keep_i;
      value_d = keep_o ? e_value : sample_i;
      pos_d   = keep_o ? e_pos   : pos_i;
    end else if (ctl_i.pop) begin
      valid_d = e_valid;
      value_d = e_value;
      pos_d   = e_pos;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    pos_q   <= pos_d;
  end

  assign valid_o = valid_q;
  assign value_o = value_q;
  assign pos_o   = pos_q;

endmodule
`default_nettype wire

// ----- hdl/swm_out_stage.sv -----
// Two-entry output stage: a result register backed by a skid register.
`default_nettype none
module swm_out_stage
  import swm_pkg::*;
#(
  parameter int WIDTH = SampleBitsDef + 1
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              push_i,
  input  wire  [WIDTH-1:0] data_i,
  output logic             space_o,
  output logic             valid_o,
  input  wire              ready_i,
  output logic [WIDTH-1:0] data_o
);

  logic             out_valid_q, out_valid_d;
  logic             skid_valid_q, skid_valid_d;
  logic [WIDTH-1:0] out_data_q, out_data_d;
  logic [WIDTH-1:0] skid_data_q, skid_data_d;
  logic             take;

  always_comb begin
    take         = out_valid_q & ready_i;
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_data_d   = out_data_q;
    skid_data_d  = skid_data_q;
    if (skid_valid_q) begin
      if (take) begin
        out_data_d   = skid_data_q;
        skid_valid_d = 1'b0;
      end
    end else if (push_i) begin
      if (!out_valid_q || take) begin
        out_valid_d = 1'b1;
        out_data_d  = data_i;
      end else begin
        skid_valid_d = 1'b1;
        skid_data_d  = data_i;
      end
    end else if (take) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign space_o = ~skid_valid_q;
  assign valid_o = out_valid_q;
  assign data_o  = out_data_q;

endmodule
`default_nettype wire

// ----- hdl/sliding_window_maximum_unit.sv -----
// Sliding window maximum over a signed sample stream, built as a chain of deque cells.
//
// Samples arrive on the in channel (in_valid_i/in_ready_o) with last_sample_i marking the
// end of a sequence. From the window_size-th sample of a sequence on, every sample beat
// produces one result beat on the out channel (out_valid_o/out_ready_i) carrying the
// maximum of the last window_size samples; earlier samples produce nothing.
// The window register is written through cfg_valid_i/cfg_ready_o; 0 acts as 1 and values
// above MAX_WINDOW act as MAX_WINDOW. Write it only while the block is idle.
// Each result is registered in the output stage before it appears on the outputs.
// Throughput is one sample per cycle while in_ready_o is high, since every cell updates
// on the sample beat itself. After the window has been made smaller, the input holds off
// while the chain pops the stale entries at the deque front one at a time.
// Reset empties the deque, clears the sequence counters and sets the window to 8.
// Results pass through a two-entry output stage, so a sample is still accepted while one
// result waits; when both entries are full because the receiver stalls, in_ready_o drops.
`default_nettype none
module sliding_window_maximum_unit
  import swm_pkg::*;
#(
  parameter int MAX_WINDOW  = MaxWindowDef,
  parameter int SAMPLE_BITS = SampleBitsDef
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           in_valid_i,
  output logic                          in_ready_o,
  input  wire signed [SAMPLE_BITS-1:0]  sample_i,
  input  wire                           last_sample_i,
  output logic                          out_valid_o,
  input  wire                           out_ready_i,
  output logic signed [SAMPLE_BITS-1:0] window_max_o,
  output logic                          end_of_sequence_o,
  input  wire                           cfg_valid_i,
  output logic                          cfg_ready_o,
  input  wire        [CfgBits-1:0]      cfg_window_size_i
);

  localparam int PW = $clog2(MAX_WINDOW);
  localparam int AW = $clog2(MAX_WINDOW + 1);
  localparam int CW = (AW > CfgBits) ? AW : CfgBits;

  logic [CfgBits-1:0] window_q;
  logic [PW-1:0]      sp_q, sp_d;
  logic [AW-1:0]      seen_q, seen_d, seen_n;
  logic [CW-1:0]      win_x;
  logic [AW-1:0]      win_eff;
  logic [AW-1:0]      sp_x, pos_x, diff, age;
  logic               aged, purge, load, push, space;
  swm_ctl_t           ctl;

  logic                          cell_valid [MAX_WINDOW];
  logic signed [SAMPLE_BITS-1:0] cell_value [MAX_WINDOW];
  logic        [PW-1:0]          cell_pos   [MAX_WINDOW];
  logic                          cell_keep  [MAX_WINDOW];

  logic signed [SAMPLE_BITS-1:0] front_val;
  logic [SAMPLE_BITS:0]          res_data;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    win_x = CW'(window_q);
    if (win_x == '0) begin
      win_eff = AW'(1);
    end else if (win_x > CW'(MAX_WINDOW)) begin
      win_eff = AW'(MAX_WINDOW);
    end else begin
      win_eff = AW'(win_x);
    end
  end

  // Age of the front entry relative to the next sample position; zero means a full lap.
  always_comb begin
    sp_x  = AW'(sp_q);
    pos_x = AW'(cell_pos[0]);
    diff  = (sp_x >= pos_x) ? (sp_x - pos_x) : (sp_x + AW'(MAX_WINDOW) - pos_x);
    age   = (diff == '0) ? AW'(MAX_WINDOW) : diff;
    aged  = cell_valid[0] & (age >= win_eff);
    purge = cell_valid[0] & (age > win_eff);
  end

  assign in_ready_o = ~purge & space;
  assign load       = in_valid_i & in_ready_o;

  always_comb begin
    ctl.load  = load;
    ctl.clear = load & last_sample_i;
    ctl.pop   = load ? aged : purge;
  end

  always_comb begin
    seen_n = (seen_q < win_eff) ? (seen_q + AW'(1)) : win_eff;
    seen_d = seen_q;
    sp_d   = sp_q;
    if (load) begin
      if (last_sample_i) begin
        seen_d = '0;
        sp_d   = '0;
      end else begin
        seen_d = seen_n;
        sp_d   = (sp_q == PW'(MAX_WINDOW - 1)) ? '0 : (sp_q + PW'(1));
      end
    end
    push = load & (seen_n == win_eff);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= WindowReset;
      sp_q     <= '0;
      seen_q   <= '0;
    end else begin
      if (cfg_valid_i) begin
        window_q <= cfg_window_size_i;
      end
      sp_q   <= sp_d;
      seen_q <= seen_d;
    end
  end

  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    logic                          prev_keep;
    logic                          nxt_valid;
    logic signed [SAMPLE_BITS-1:0] nxt_value;
    logic        [PW-1:0]          nxt_pos;

    if (i == 0) begin : g_head
      assign prev_keep = 1'b1;
    end else begin : g_body
      assign prev_keep = cell_keep[i-1];
    end

    if (i == MAX_WINDOW - 1) begin : g_tail
      assign nxt_valid = 1'b0;
      assign nxt_value = '0;
      assign nxt_pos   = '0;
    end else begin : g_link
      assign nxt_valid = cell_valid[i+1];
      assign nxt_value = cell_value[i+1];
      assign nxt_pos   = cell_pos[i+1];
    end

    swm_cell #(
      .SAMPLE_BITS(SAMPLE_BITS),
      .POS_BITS   (PW)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (ctl),
      .sample_i    (sample_i),
      .pos_i       (sp_q),
      .prev_keep_i (prev_keep),
      .next_valid_i(nxt_valid),
      .next_value_i(nxt_value),
      .next_pos_i  (nxt_pos),
      .valid_o     (cell_valid[i]),
      .value_o     (cell_value[i]),
      .pos_o       (cell_pos[i]),
      .keep_o      (cell_keep[i])
    );
  end

  // The new front of the deque is the window maximum.
  assign front_val = cell_keep[0] ? (ctl.pop ? cell_value[1] : cell_value[0]) : sample_i;
  assign res_data  = {last_sample_i, front_val};

  swm_out_stage #(
    .WIDTH(SAMPLE_BITS + 1)
  ) u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (res_data),
    .space_o(space),
    .valid_o(out_valid_o),
    .ready_i(out_ready_i),
    .data_o ({end_of_sequence_o, window_max_o})
  );

endmodule
`default_nettype wire

// ----- hdl/swm_checker.sv -----
// Port-level checks for the sliding window maximum unit, bound to its top level.
`default_nettype none
module swm_checker
  import swm_pkg::*;
#(
  parameter int SAMPLE_BITS = SampleBitsDef
) (
  input wire                    clk_i,
  input wire                    rst_ni,
  input wire                    in_valid_i,
  input wire                    in_ready_o,
  input wire [SAMPLE_BITS-1:0]  sample_i,
  input wire                    last_sample_i,
  input wire                    out_valid_o,
  input wire                    out_ready_i,
  input wire [SAMPLE_BITS-1:0]  window_max_o,
  input wire                    end_of_sequence_o,
  input wire                    cfg_valid_i,
  input wire                    cfg_ready_o
);

  // A waiting sample beat stays offered with the same payload.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(sample_i)
      && $stable(last_sample_i))
    else $error("waiting sample changed");

  // A stalled result beat keeps its value until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(window_max_o)
      && $stable(end_of_sequence_o))
    else $error("stalled result changed");

  // A result only appears right after a sample beat.
  a_out_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o))
    else $error("result without a sample beat");

  // A result only leaves when the receiver took it.
  a_out_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_o) |-> $past(out_ready_i))
    else $error("result dropped");

  // The window register never holds off a write.
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration write stalled");

endmodule

bind sliding_window_maximum_unit swm_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_swm_checker (.*);
`default_nettype wire

// ----- tb/sliding_window_maximum_unit_tb.sv -----
// Self-checking testbench for the sliding window maximum unit.
`default_nettype none
module sliding_window_maximum_unit_tb;
  import swm_pkg::*;

  localparam int PosBits     = $clog2(MaxWindowDef);
  localparam int CfgSettle   = MaxWindowDef + 8;
  localparam int DrainCycles = 8;
  localparam int HoldCycles  = 300;
  localparam int CycleLimit  = 500000;
  localparam int PhaseItems  = 210;

  typedef logic signed [SampleBitsDef-1:0] sample_t;

  typedef struct packed {
    sample_t window_max;
    logic    end_of_sequence;
  } max_result_t;

  typedef enum int {
    PatRandom,
    PatTies,
    PatRamp,
    PatExtremes
  } pattern_t;

  logic               clk_i             = 1'b0;
  logic               rst_ni            = 1'b0;
  logic               in_valid_i        = 1'b0;
  logic               in_ready_o;
  sample_t            sample_i          = '0;
  logic               last_sample_i     = 1'b0;
  logic               out_valid_o;
  logic               out_ready_i       = 1'b0;
  sample_t            window_max_o;
  logic               end_of_sequence_o;
  logic               cfg_valid_i       = 1'b0;
  logic               cfg_ready_o;
  logic [CfgBits-1:0] cfg_window_size_i = '0;

  sliding_window_maximum_unit u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .sample_i          (sample_i),
    .last_sample_i     (last_sample_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .window_max_o      (window_max_o),
    .end_of_sequence_o (end_of_sequence_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_window_size_i (cfg_window_size_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Handshake flags, sampled at the falling edge and used at the next rising edge.
  bit in_fire  = 1'b0;
  bit out_fire = 1'b0;
  bit cfg_fire = 1'b0;

  int fail_count      = 0;
  int items_sent      = 0;
  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;
  logic hold_req      = 1'b0;
  int hold_left       = 0;

  max_result_t expected_max_q[$];

  // Tracked deque of candidate maxima, oldest at index 0.
  sample_t            dq_val [MaxWindowDef];
  logic [PosBits-1:0] dq_pos [MaxWindowDef];
  int                 dq_len     = 0;
  logic [PosBits-1:0] next_pos   = '0;
  int                 seen_count = 0;
  logic [CfgBits-1:0] window_reg = WindowReset;

  function automatic int effective_window(input logic [CfgBits-1:0] v);
    int w;
    w = int'(v);
    if (w == 0) w = 1;
    if (w > MaxWindowDef) w = MaxWindowDef;
    return w;
  endfunction

  function automatic void track_window_max(input sample_t s, input logic last,
                                           output bit has_max, output max_result_t res);
    int w;
    int age;
    logic [PosBits-1:0] age_raw;
    w = effective_window(window_reg);
    has_max = 1'b0;
    res = '0;
    // An age of zero wraps to a full window since the new beat is not in the deque yet.
    while (dq_len > 0) begin
      age_raw = next_pos - dq_pos[0];
      age = (age_raw == '0) ? MaxWindowDef : int'(age_raw);
      if (age < w) break;
      for (int i = 1; i < dq_len; i++) begin
        dq_val[i-1] = dq_val[i];
        dq_pos[i-1] = dq_pos[i];
      end
      dq_len--;
    end
    while (dq_len > 0 && dq_val[dq_len-1] <= s) dq_len--;
    dq_val[dq_len] = s;
    dq_pos[dq_len] = next_pos;
    dq_len++;
    next_pos = next_pos + 1'b1;
    if (seen_count < w) seen_count++;
    if (seen_count > w) seen_count = w;
    if (seen_count >= w) begin
      has_max = 1'b1;
      res.window_max = dq_val[0];
      res.end_of_sequence = last;
    end
    if (last) begin
      dq_len = 0;
      next_pos = '0;
      seen_count = 0;
    end
  endfunction

  always @(negedge clk_i) begin : monitor
    max_result_t want;
    bit has_max;
    in_fire  = rst_ni && in_valid_i && (in_ready_o === 1'b1);
    out_fire = rst_ni && (out_valid_o === 1'b1) && out_ready_i;
    cfg_fire = rst_ni && cfg_valid_i && (cfg_ready_o === 1'b1);
    if (cfg_fire) window_reg = cfg_window_size_i;
    if (out_fire) begin
      if (expected_max_q.size() == 0) begin
        $error("unexpected result beat: window_max %0d, end_of_sequence %0b",
               window_max_o, end_of_sequence_o);
        fail_count++;
      end else begin
        want = expected_max_q[0];
        expected_max_q.delete(0);
        if (window_max_o !== want.window_max) begin
          $error("window_max: expected %0d, actual %0d", want.window_max, window_max_o);
          fail_count++;
        end
        if (end_of_sequence_o !== want.end_of_sequence) begin
          $error("end_of_sequence: expected %0b, actual %0b",
                 want.end_of_sequence, end_of_sequence_o);
          fail_count++;
        end
      end
    end
    if (in_fire) begin
      track_window_max(sample_i, last_sample_i, has_max, want);
      if (has_max) expected_max_q = {expected_max_q, want};
    end
  end

  // Receiver: random stalls, plus a long hold-off counted here on request.
  always @(posedge clk_i) begin
    if (hold_req && hold_left == 0) hold_left = HoldCycles;
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin : watchdog
    for (int n = 0; n < CycleLimit; n++) @(posedge clk_i);
    $display("sliding_window_maximum_unit verification failed");
    $finish;
  end

  task automatic send_sample(input sample_t s, input logic last);
    int gap;
    gap = 0;
    while ($urandom_range(99) < sender_idle_pct && gap < 20) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    sample_i      <= s;
    last_sample_i <= last;
    @(posedge clk_i);
    while (!in_fire) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic wait_idle(input int settle);
    in_valid_i <= 1'b0;
    while (expected_max_q.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  // The chain may still be popping stale entries, so the write waits for the results to drain and the chain to settle.
  task automatic write_window(input logic [CfgBits-1:0] v);
    wait_idle(CfgSettle);
    cfg_valid_i       <= 1'b1;
    cfg_window_size_i <= v;
    @(posedge clk_i);
    while (!cfg_fire) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_sequence(input int len, input bit close);
    pattern_t pattern;
    sample_t s;
    bit rising;
    pattern = pattern_t'($urandom_range(3));
    rising = 1'($urandom_range(1));
    s = $urandom;
    for (int i = 0; i < len; i++) begin
      case (pattern)
        PatRandom: s = $urandom;
        PatTies:   s = sample_t'(int'($urandom_range(8)) - 4);
        PatRamp:   s = rising ? s + sample_t'($urandom_range(3)) : s - sample_t'($urandom_range(3));
        default: begin
          case ($urandom_range(3))
            0:       s = 32'sh7FFF_FFFF;
            1:       s = 32'sh8000_0000;
            2:       s = -1;
            default: s = sample_t'($urandom_range(1));
          endcase
        end
      endcase
      send_sample(s, close && (i == len - 1));
    end
  endtask

  function automatic logic [CfgBits-1:0] pick_window();
    case ($urandom_range(9))
      0:       return '0;
      1:       return 7'd1;
      2:       return 7'd2;
      3:       return 7'd3;
      4:       return 7'($urandom_range(4, 12));
      5:       return 7'($urandom_range(13, 40));
      6:       return 7'd64;
      7:       return 7'd127;
      8:       return 7'($urandom_range(65, 126));
      default: return 7'($urandom_range(1, 8));
    endcase
  endfunction

  task automatic test_default_window();
    send_sample(32'sh7FFF_FFFF, 1'b0);
    send_sample(32'sh8000_0000, 1'b0);
    send_sample(-1, 1'b0);
    send_sample(0, 1'b0);
    send_sample(1, 1'b0);
    send_sample(-2, 1'b0);
    send_sample(100, 1'b0);
    send_sample(-100, 1'b0);
    send_sample(5, 1'b1);
  endtask

  // With a window of one, every result is its own sample, repeated equal values included.
  task automatic test_window_one();
    write_window(7'd1);
    send_sample(32'sh8000_0000, 1'b0);
    send_sample(32'sh8000_0000, 1'b0);
    send_sample(7, 1'b0);
    send_sample(32'sh7FFF_FFFF, 1'b1);
  endtask

  task automatic test_window_zero();
    write_window('0);
    send_sample(-5, 1'b0);
    send_sample(-5, 1'b1);
  endtask

  task automatic test_short_sequence();
    write_window(7'd4);
    send_sample(3, 1'b0);
    send_sample(2, 1'b0);
    send_sample(1, 1'b1);
  endtask

  // A falling ramp fills the deque, then a smaller window ages out several entries, popped one at a time.
  task automatic test_window_shrink();
    write_window(7'd8);
    send_sample(50, 1'b0);
    send_sample(40, 1'b0);
    send_sample(30, 1'b0);
    send_sample(20, 1'b0);
    send_sample(10, 1'b0);
    write_window(7'd2);
    send_sample(5, 1'b0);
    send_sample(4, 1'b1);
  endtask

  task automatic test_backpressure();
    write_window(7'd1);
    hold_req <= 1'b1;
    @(posedge clk_i);
    hold_req <= 1'b0;
    run_sequence(40, 1'b1);
    write_window(7'd3);
    run_sequence(12, 1'b0);
    wait_idle(DrainCycles);
    run_sequence(12, 1'b1);
  endtask

  task automatic test_random_streams();
    int sender_pct [4] = '{0, 50, 0, 33};
    int recv_pct [4] = '{0, 0, 50, 33};
    int phase_start;
    int w;
    int nseq;
    int len;
    bit close;
    logic [CfgBits-1:0] reg_val;
    for (int p = 0; p < 4; p++) begin
      sender_idle_pct = sender_pct[p];
      recv_stall_pct  = recv_pct[p];
      phase_start = items_sent;
      while (items_sent - phase_start < PhaseItems) begin
        reg_val = pick_window();
        write_window(reg_val);
        w = effective_window(reg_val);
        nseq = (w >= 32) ? 1 : $urandom_range(1, 3);
        for (int q = 0; q < nseq; q++) begin
          if ($urandom_range(9) == 0) len = (w > 1) ? $urandom_range(1, w - 1) : 1;
          else len = $urandom_range(w, w + 24);
          // Now and then a sequence stays open across the next window change.
          close = (q < nseq - 1) || ($urandom_range(4) != 0);
          run_sequence(len, close);
        end
      end
    end
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_default_window();
    test_window_one();
    test_window_zero();
    test_short_sequence();
    test_window_shrink();
    test_backpressure();
    test_random_streams();
    wait_idle(DrainCycles);
    if (expected_max_q.size() != 0) begin
      $error("%0d expected window maxima never arrived", expected_max_q.size());
      fail_count++;
    end
    if (fail_count == 0) $display("sliding_window_maximum_unit verification clean");
    else $display("sliding_window_maximum_unit verification failed");
    $finish;
  end

endmodule
`default_nettype wire
